// ===== design/pp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the polygon perimeter block: widths, item types and the
// command/status structs between controller and datapath. No dependencies.
package pp_pkg;

	localparam int COORD_W    = 16;
	localparam int SUM_W      = 40;
	localparam int FRAC_SHIFT = 16;

	localparam int SQ_W   = 2 * COORD_W;
	localparam int SQS_W  = SQ_W + 1;
	localparam int ROOT_W = (SQS_W + FRAC_SHIFT + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);
	localparam int EXT_W  = ((SUM_W > ROOT_W) ? SUM_W : ROOT_W) + 1;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic                      last_vertex;
	} pp_in_t;

	typedef struct packed {
		logic [SUM_W-1:0] perimeter;
		logic             saturated;
	} pp_out_t;

	typedef struct packed {
		logic accept;
		logic closing;
		logic load_diff;
		logic mul_x;
		logic mul_y;
		logic root_load;
		logic root_step;
		logic add;
		logic finish;
		logic emit;
	} pp_cmd_t;

	typedef struct packed {
		logic have_first;
		logic last;
		logic root_done;
		logic out_free;
	} pp_sts_t;

endpackage

// ===== design/pp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: vertex registers, abs difference, shared squaring multiplier,
// digit-by-digit square root, saturating accumulator and result register. Uses pp_pkg.
module pp_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  pp_pkg::pp_in_t  vtx,
	input  pp_pkg::pp_cmd_t cmd,
	output pp_pkg::pp_sts_t sts,
	output logic            res_valid,
	input  logic            res_stall,
	output pp_pkg::pp_out_t res
);
	import pp_pkg::*;

	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q;
	logic                      last_q;
	logic                      have_first_q;
	logic [COORD_W-1:0]        dx_q, dy_q;
	logic [SQ_W-1:0]           sqx_q;
	logic [SQS_W-1:0]          sq_sum_q;
	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      clip_q;
	logic                      res_valid_q;
	pp_out_t                   res_q;

	logic signed [COORD_W-1:0] ax, ay, bx, by;
	logic signed [COORD_W:0]   ddx, ddy;
	logic [COORD_W-1:0]        mdx, mdy, mul_op;
	logic [SQ_W-1:0]           prod;
	logic [REM_W-1:0]          rem_sh, trial;
	logic [EXT_W-1:0]          total;
	logic                      over;

	// operand pair: open edge prev->cur, closing edge cur->first
	always_comb begin
		ax = cmd.closing ? cur_x_q : prev_x_q;
		ay = cmd.closing ? cur_y_q : prev_y_q;
		bx = cmd.closing ? first_x_q : cur_x_q;
		by = cmd.closing ? first_y_q : cur_y_q;
		ddx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
		ddy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
		mdx = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
		mdy = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
	end

	assign mul_op = cmd.mul_y ? dy_q : dx_q;
	assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	assign total = EXT_W'(sum_q) + EXT_W'(root_q);
	assign over  = total > EXT_W'(SUM_MAX);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_x_q <= vtx.x_coord;
			cur_y_q <= vtx.y_coord;
			last_q  <= vtx.last_vertex;
			if (!have_first_q) begin
				first_x_q <= vtx.x_coord;
				first_y_q <= vtx.y_coord;
			end
		end
		if (cmd.finish)
			prev_x_q <= cur_x_q;
		if (cmd.finish)
			prev_y_q <= cur_y_q;
		if (cmd.load_diff) begin
			dx_q <= mdx;
			dy_q <= mdy;
		end
		if (cmd.mul_x)
			sqx_q <= prod;
		if (cmd.mul_y)
			sq_sum_q <= SQS_W'(sqx_q) + SQS_W'(prod);
		if (cmd.root_load) begin
			rad_q  <= RAD_W'({sq_sum_q, {FRAC_SHIFT{1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			res_q.perimeter <= sum_q;
			res_q.saturated <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			sum_q        <= '0;
			clip_q       <= 1'b0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.root_load)
				cnt_q <= CNT_W'(ROOT_W);
			else if (cmd.root_step)
				cnt_q <= cnt_q - CNT_W'(1);
			if (cmd.add) begin
				sum_q  <= over ? SUM_MAX : total[SUM_W-1:0];
				clip_q <= clip_q | over;
			end
			if (cmd.finish) begin
				have_first_q <= !last_q;
				if (last_q) begin
					sum_q  <= '0;
					clip_q <= 1'b0;
				end
			end
			if (cmd.emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	assign sts.have_first = have_first_q;
	assign sts.last       = last_q;
	assign sts.root_done  = (cnt_q == '0);
	assign sts.out_free   = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_step_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_step |-> cnt_q != '0)
		else $error("root step issued after last digit");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten while held");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && last_q |=> sum_q == '0 && !clip_q && !have_first_q)
		else $error("polygon state not cleared");
	a_clip_max: assert property (@(posedge clk) disable iff (!arst_n)
		clip_q |-> sum_q == SUM_MAX)
		else $error("clipped sum below maximum");

endmodule

// ===== design/pp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences the open and closing edge of each
// item through the datapath. Uses pp_pkg for the command/status structs.
module pp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pp_pkg::pp_sts_t sts,
	output pp_pkg::pp_cmd_t cmd
);
	import pp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SEL   = 3'd1;
	localparam logic [2:0] S_DIFF  = 3'd2;
	localparam logic [2:0] S_MULX  = 3'd3;
	localparam logic [2:0] S_MULY  = 3'd4;
	localparam logic [2:0] S_RLOAD = 3'd5;
	localparam logic [2:0] S_ROOT  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       closing_q, closing_d;
	logic       add_pending_q, add_pending_d;

	always_comb begin
		state_d       = state_q;
		closing_d     = closing_q;
		add_pending_d = 1'b0;
		cmd           = '0;
		cmd.closing   = closing_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_SEL;
				end
			end
			S_SEL: begin
				if (sts.have_first) begin
					closing_d = 1'b0;
					state_d   = S_DIFF;
				end else if (sts.last) begin
					closing_d = 1'b1;
					state_d   = S_DIFF;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIFF: begin
				cmd.load_diff = 1'b1;
				state_d       = S_MULX;
			end
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = S_MULY;
			end
			S_MULY: begin
				cmd.mul_y = 1'b1;
				state_d   = S_RLOAD;
			end
			S_RLOAD: begin
				cmd.root_load = 1'b1;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				if (!sts.root_done) begin
					cmd.root_step = 1'b1;
				end else begin
					cmd.add = 1'b1;
					if (!closing_q && sts.last) begin
						closing_d = 1'b1;
						state_d   = S_DIFF;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (!sts.last || sts.out_free) begin
					cmd.finish = 1'b1;
					cmd.emit   = sts.last;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			closing_q     <= 1'b0;
			add_pending_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			closing_q     <= closing_d;
			add_pending_q <= add_pending_d | cmd.add;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_SEL)
		else $error("accepted item not sequenced");
	a_add_then_next: assert property (@(posedge clk) disable iff (!arst_n)
		add_pending_q |-> state_q == S_DIFF || state_q == S_FIN)
		else $error("bad state after accumulate");
	a_close_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add && closing_q |=> state_q == S_FIN)
		else $error("closing edge repeated");

endmodule

// ===== design/polygon_perimeter.sv =====
`timescale 1ns / 1ps
// Top level of the polygon perimeter block: joins the controller and the
// datapath. Depends on pp_pkg, pp_ctrl and pp_dp.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------
//   vertex  | vtx_valid | vtx_stall | vtx : x_coord, y_coord, last_vertex
//   result  | res_valid | res_stall | res : perimeter, saturated
//
// One item at a time. An edge is bounded by the 2-bit-per-cycle square
// root (25 steps). A first vertex computes no edge, a following vertex its
// open edge, the last one its open and closing edge, or the closing alone.
// arst_n clears control, the running sum and the held vertex flag.
// A new vertex is taken while a result waits; the block holds in its final
// step only if a second result is ready before res_stall drops.
module polygon_perimeter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vtx_valid,
	output logic            vtx_stall,
	input  pp_pkg::pp_in_t  vtx,
	output logic            res_valid,
	input  logic            res_stall,
	output pp_pkg::pp_out_t res
);
	import pp_pkg::*;

	pp_cmd_t cmd;
	pp_sts_t sts;
	logic    busy;
	logic    start;

	assign vtx_stall = busy;
	assign start     = vtx_valid && !busy;

	pp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
